@@ hdl/assert_macros.svh @@
// Assertion macros for the curve evaluator top module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define CRE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define CRE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CRE_ASSERT_IMPL(lbl, ante, cons)
`define CRE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ hdl/cre_pkg.sv @@
// Types, constants and helper functions shared by the curve evaluator.
package cre_pkg;

  localparam int COORD_W  = 32;
  localparam int T_W      = 17;
  localparam int T_FRAC   = 16;
  localparam int COEF_W   = 36;
  localparam int ACC_W    = 42;
  localparam int NUM_REGS = 8;
  localparam int IDX_W    = 3;

  localparam logic [T_W-1:0] T_ONE = T_W'(1) << T_FRAC;

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  // Request and result payloads.
  typedef struct packed {
    logic           func;
    logic [T_W-1:0] t;
    logic [T_W-1:0] t_end;
  } req_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] slope_x;
    logic signed [COORD_W-1:0] slope_y;
    logic signed [COORD_W-1:0] area;
    logic                      clipped;
  } res_t;

  typedef logic [NUM_REGS-1:0][COEF_W-1:0] coef_arr_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  // What a Horner lane computes.
  typedef enum logic [2:0] {
    KIND_POS_X,
    KIND_POS_Y,
    KIND_SLP_X,
    KIND_SLP_Y,
    KIND_INT
  } kind_t;

  // Parameter values above one are clamped to one.
  function automatic logic [T_W-1:0] clamp_t(input logic [T_W-1:0] x);
    return (x > T_ONE) ? T_ONE : x;
  endfunction

  // Lane assignment: four evaluations, or an antiderivative in every lane.
  function automatic kind_t lane_kind(input logic func, input logic [1:0] lane);
    kind_t k;
    k = KIND_INT;
    if (!func) begin
      case (lane)
        2'd0:    k = KIND_POS_X;
        2'd1:    k = KIND_POS_Y;
        2'd2:    k = KIND_SLP_X;
        default: k = KIND_SLP_Y;
      endcase
    end
    return k;
  endfunction

  // One coefficient, sign extended to the accumulator width.
  function automatic acc_t cx(input coef_arr_t c, input logic [IDX_W-1:0] i);
    return acc_t'($signed(c[i]));
  endfunction

  // Accumulator value entering the first Horner step.
  function automatic acc_t init_k(input coef_arr_t c, input kind_t kind);
    return (kind == KIND_INT) ? cx(c, 3'd4) * acc_t'(3) : '0;
  endfunction

  // Term added after the product in Horner step number step (0 to 3).
  function automatic acc_t step_k(input coef_arr_t c, input kind_t kind,
                                  input logic [1:0] step);
    acc_t k;
    logic [IDX_W-1:0] b;
    k = '0;
    b = (kind == KIND_POS_Y || kind == KIND_SLP_Y || kind == KIND_INT) ? 3'd4 : 3'd0;
    case (kind) inside
      KIND_POS_X, KIND_POS_Y: k = cx(c, b + {1'b0, step});
      KIND_SLP_X, KIND_SLP_Y: begin
        case (step)
          2'd0:    k = '0;
          2'd1:    k = cx(c, b) * acc_t'(3);
          2'd2:    k = cx(c, b + 3'd1) * acc_t'(2);
          default: k = cx(c, b + 3'd2);
        endcase
      end
      KIND_INT: begin
        case (step)
          2'd0:    k = cx(c, b + 3'd1) * acc_t'(4);
          2'd1:    k = cx(c, b + 3'd2) * acc_t'(6);
          2'd2:    k = cx(c, b + 3'd3) * acc_t'(12);
          default: k = '0;
        endcase
      end
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

@@ hdl/cre_fit.sv @@
// Control point registers and the Catmull-Rom coefficient fit.
module cre_fit import cre_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [COORD_W-1:0] cfg_data,
  output coef_arr_t          coefs
);

  logic signed [COORD_W-1:0] regs [NUM_REGS];

  // Control points; every index of the port names a register.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) regs[i] <= '0;
    end else if (cfg_we) begin
      regs[cfg_index] <= cfg_data;
    end
  end

  // Doubled cubic coefficients per axis, exact in raw units.
  genvar ax;
  for (ax = 0; ax < 2; ax++) begin : g_axis
    logic signed [COEF_W-1:0] pm, p0, p1, p2;
    assign pm = COEF_W'(regs[ax]);
    assign p0 = COEF_W'(regs[2 + ax]);
    assign p1 = COEF_W'(regs[4 + ax]);
    assign p2 = COEF_W'(regs[6 + ax]);
    assign coefs[4*ax + 0] = p0 * COEF_W'(3) - p1 * COEF_W'(3) - pm + p2;
    assign coefs[4*ax + 1] = pm * COEF_W'(2) - p0 * COEF_W'(5) + p1 * COEF_W'(4) - p2;
    assign coefs[4*ax + 2] = p1 - pm;
    assign coefs[4*ax + 3] = p0 * COEF_W'(2);
  end

endmodule

@@ hdl/cre_step.sv @@
// One registered Horner step: rounded product with the parameter plus a term.
module cre_step import cre_pkg::*; (
  input  logic           clk,
  input  logic           en,
  input  acc_t           acc_in,
  input  logic [T_W-1:0] u_in,
  input  kind_t          kind_in,
  input  logic [1:0]     step,
  input  coef_arr_t      coefs,
  output acc_t           acc,
  output logic [T_W-1:0] u,
  output kind_t          kind
);

  localparam int PROD_W = ACC_W + T_W;

  logic [ACC_W-1:0]  mag;
  logic [PROD_W-1:0] prod;
  logic [ACC_W-1:0]  rnd;
  acc_t              scaled;

  // Sign-magnitude product, rounded to nearest with ties away from zero.
  assign mag    = acc_in[ACC_W-1] ? ACC_W'(-acc_in) : ACC_W'(acc_in);
  assign prod   = PROD_W'(mag) * PROD_W'(u_in);
  assign rnd    = ACC_W'((prod + PROD_W'(1 << (T_FRAC - 1))) >> T_FRAC);
  assign scaled = acc_in[ACC_W-1] ? -$signed(rnd) : $signed(rnd);

  // Stage register; parameter and lane kind travel with the sum.
  always_ff @(posedge clk) begin
    if (en) begin
      acc  <= scaled + step_k(coefs, kind_in, step);
      u    <= u_in;
      kind <= kind_in;
    end
  end

endmodule

@@ hdl/cre_post.sv @@
// Final scaling: halving and saturation, and the division of the integral by 24.
module cre_post import cre_pkg::*; (
  input  logic       clk,
  input  logic [2:0] en,
  input  acc_t       lane_acc [4],
  input  logic       func,
  output res_t       res
);

  localparam int DIV_SPLIT   = 16;
  localparam int DIV3_SHIFT  = 20;
  localparam int DIV3_W      = 19;
  localparam logic [DIV3_W-1:0] DIV3_MUL = 19'd349526;
  localparam int HI_W        = COORD_W + 1 - DIV_SPLIT;
  localparam logic [ACC_W:0] Q_POS_LIM = (ACC_W+1)'(3) << (COORD_W - 1);
  localparam logic [ACC_W:0] Q_NEG_LIM = Q_POS_LIM + (ACC_W+1)'(3);

  logic signed [COORD_W-1:0] half_val [4];
  logic [3:0]                half_clip;

  // Position and slope: halve with rounding, then saturate.
  genvar L;
  for (L = 0; L < 4; L++) begin : g_half
    logic [ACC_W-1:0] m, h;
    acc_t             hs;
    logic             hi, lo;
    assign m  = lane_acc[L][ACC_W-1] ? ACC_W'(-lane_acc[L]) : ACC_W'(lane_acc[L]);
    assign h  = (m + ACC_W'(1)) >> 1;
    assign hs = lane_acc[L][ACC_W-1] ? -$signed(h) : $signed(h);
    assign hi = hs > acc_t'(COORD_MAX);
    assign lo = hs < acc_t'(COORD_MIN);
    assign half_clip[L] = hi || lo;
    assign half_val[L]  = hi ? COORD_MAX : (lo ? COORD_MIN : COORD_W'(hs));
  end

  // Integral: magnitude of the difference, rounded and divided by eight.
  logic signed [ACC_W:0] diff;
  logic [ACC_W:0]        dmag, q;
  logic                  neg, over;
  assign diff = (ACC_W+1)'(lane_acc[0]) - (ACC_W+1)'(lane_acc[1]);
  assign neg  = diff[ACC_W];
  assign dmag = neg ? (ACC_W+1)'(-diff) : (ACC_W+1)'(diff);
  assign q    = (dmag + (ACC_W+1)'(12)) >> 3;
  assign over = neg ? (q >= Q_NEG_LIM) : (q >= Q_POS_LIM);

  res_t             s5_base, s6_base;
  res_t             eval_res;
  logic             s5_func, s5_neg, s5_over, s6_func, s6_neg, s6_over;
  logic [COORD_W:0] s5_q;
  logic [15:0]      s6_a1, s6_ql;
  logic [1:0]       s6_r1;

  // Evaluation fields of the result; all zero for an integral.
  always_comb begin
    eval_res = '0;
    if (!func) begin
      eval_res.pos_x   = half_val[0];
      eval_res.pos_y   = half_val[1];
      eval_res.slope_x = half_val[2];
      eval_res.slope_y = half_val[3];
      eval_res.clipped = |half_clip;
    end
  end

  // Stage five: scaled evaluations and the integral quotient by eight.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      s5_base <= eval_res;
      s5_func <= func;
      s5_neg  <= neg;
      s5_over <= over;
      s5_q    <= over ? '0 : q[COORD_W:0];
    end
  end

  // Stage six: upper digits divided by three through a reciprocal.
  logic [HI_W-1:0]          qh;
  logic [HI_W+DIV3_W-1:0]   prod1;
  logic [15:0]              a1;
  assign qh    = s5_q[COORD_W:DIV_SPLIT];
  assign prod1 = (HI_W+DIV3_W)'(qh) * (HI_W+DIV3_W)'(DIV3_MUL);
  assign a1    = 16'(prod1 >> DIV3_SHIFT);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s6_base <= s5_base;
      s6_func <= s5_func;
      s6_neg  <= s5_neg;
      s6_over <= s5_over;
      s6_a1   <= a1;
      s6_r1   <= 2'(qh - HI_W'(a1) * HI_W'(3));
      s6_ql   <= s5_q[DIV_SPLIT-1:0];
    end
  end

  // Stage seven: remainder with the lower digits divided by three, then sign.
  logic [DIV_SPLIT+1:0]            n;
  logic [DIV_SPLIT+2+DIV3_W-1:0]   prod2;
  logic [COORD_W-1:0]              qmag;
  logic signed [COORD_W-1:0]       area_v;
  res_t                            out_res;
  assign n      = {s6_r1, s6_ql};
  assign prod2  = (DIV_SPLIT+2+DIV3_W)'(n) * (DIV_SPLIT+2+DIV3_W)'(DIV3_MUL);
  assign qmag   = {s6_a1, 16'(prod2 >> DIV3_SHIFT)};
  assign area_v = s6_over ? (s6_neg ? COORD_MIN : COORD_MAX)
                          : (s6_neg ? $signed(-qmag) : $signed(qmag));

  // Complete result with the area and the combined clip flag.
  always_comb begin
    out_res         = s6_base;
    out_res.area    = s6_func ? area_v : '0;
    out_res.clipped = s6_base.clipped | (s6_func & s6_over);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      res <= out_res;
    end
  end

endmodule

@@ hdl/catmull_rom_curve_evaluator_top.sv @@
// Throughput: one request per cycle; each stage advances on its own when
// the one after it is empty or moving, so stalls close bubbles.
// The entry register, the four Horner steps and the three scaling stages set the depth.
// Reset clears the control points (and so the coefficients) and empties the pipeline.
`include "assert_macros.svh"
module catmull_rom_curve_evaluator_top import cre_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [COORD_W-1:0] cfg_data,
  input  logic               req_valid,
  output logic               req_stall,
  input  req_t               req,
  output logic               res_valid,
  input  logic               res_stall,
  output res_t               res
);

  coef_arr_t coefs;

  cre_fit u_fit (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coefs     (coefs)
  );

  // Stage valids and per-stage enables; a stage loads when it is empty
  // or the stage after it loads.
  logic [7:0] v;
  logic [8:0] en;

  always_comb begin
    en[8] = !res_stall;
    for (int i = 7; i >= 0; i--) en[i] = !v[i] || en[i+1];
  end

  assign req_stall = !en[0];
  assign res_valid = v[7];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= req_valid;
      for (int i = 1; i < 8; i++) begin
        if (en[i]) v[i] <= v[i-1];
      end
    end
  end

  // Four Horner lanes: an entry register and four steps each.
  acc_t           acc_c  [4][5];
  logic [T_W-1:0] u_c    [4][5];
  kind_t          kind_c [4][5];

  genvar L, S;
  for (L = 0; L < 4; L++) begin : g_lane
    always_ff @(posedge clk) begin
      if (en[0]) begin
        kind_c[L][0] <= lane_kind(req.func, 2'(L));
        acc_c[L][0]  <= init_k(coefs, lane_kind(req.func, 2'(L)));
        u_c[L][0]    <= (L == 0 && req.func) ? clamp_t(req.t_end) : clamp_t(req.t);
      end
    end

    for (S = 0; S < 4; S++) begin : g_step
      cre_step u_step (
        .clk     (clk),
        .en      (en[S+1]),
        .acc_in  (acc_c[L][S]),
        .u_in    (u_c[L][S]),
        .kind_in (kind_c[L][S]),
        .step    (2'(S)),
        .coefs   (coefs),
        .acc     (acc_c[L][S+1]),
        .u       (u_c[L][S+1]),
        .kind    (kind_c[L][S+1])
      );
    end
  end

  // Scaling stages; the first lane tells which function the item asked for.
  acc_t lane_out [4];
  for (L = 0; L < 4; L++) begin : g_out
    assign lane_out[L] = acc_c[L][4];
  end

  cre_post u_post (
    .clk      (clk),
    .en       (en[7:5]),
    .lane_acc (lane_out),
    .func     (kind_c[0][4] == KIND_INT),
    .res      (res)
  );

  // A clipped result carries at least one field at a saturation limit.
  logic at_limit;
  assign at_limit = res.pos_x == COORD_MAX || res.pos_x == COORD_MIN ||
                    res.pos_y == COORD_MAX || res.pos_y == COORD_MIN ||
                    res.slope_x == COORD_MAX || res.slope_x == COORD_MIN ||
                    res.slope_y == COORD_MAX || res.slope_y == COORD_MIN ||
                    res.area == COORD_MAX || res.area == COORD_MIN;

  `CRE_ASSERT_IMPL(a_clip_at_limit, res_valid && res.clipped, at_limit)
  `CRE_ASSERT_NEXT(a_req_enters, req_valid && !req_stall, v[0])
  `CRE_ASSERT_IMPL(a_empty_takes, !v[0], !req_stall)
  `CRE_ASSERT_IMPL(a_full_stalls, (&v) && res_stall, req_stall)

endmodule

@@ tb/sv/tb_catmull_rom_curve_evaluator_top.sv @@
// Testbench for the Catmull-Rom curve evaluator: directed and random requests against a predictor.
module tb_catmull_rom_curve_evaluator_top;
  import cre_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  // Register indexes of the control points.
  typedef enum logic [IDX_W-1:0] {
    REG_BEFORE_X, REG_BEFORE_Y, REG_START_X, REG_START_Y,
    REG_FINISH_X, REG_FINISH_Y, REG_AFTER_X, REG_AFTER_Y
  } reg_idx_t;

  localparam logic FUNC_EVAL = 1'b0;
  localparam logic FUNC_AREA = 1'b1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [COORD_W-1:0] cfg_data = '0;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic res_valid;
  logic res_stall = 1'b1;
  res_t res;

  catmull_rom_curve_evaluator_top dut (.*);

  always #5 clk = ~clk;

  // Predictor state: control points and doubled coefficients.
  longint points [8];
  longint coefs [8];
  res_t expected_results [$];
  int failures = 0;
  bit hold_off = 1'b0;
  int idle_cycles = 0;

  function automatic longint round_by_t(longint x, longint t);
    longint m, r;
    m = (x < 0) ? -x : x;
    r = (m >>> T_FRAC) * t + (((m & 64'hFFFF) * t + 32768) >>> T_FRAC);
    return (x < 0) ? -r : r;
  endfunction

  function automatic longint round_div(longint x, longint d);
    longint m, r;
    m = (x < 0) ? -x : x;
    r = (m + d / 2) / d;
    return (x < 0) ? -r : r;
  endfunction

  function automatic logic [COORD_W-1:0] saturate(longint x, ref logic clip);
    if (x > 64'sd2147483647) begin
      clip = 1'b1;
      return COORD_MAX;
    end
    if (x < -64'sd2147483648) begin
      clip = 1'b1;
      return COORD_MIN;
    end
    return x[COORD_W-1:0];
  endfunction

  // Refit both axes after any register write.
  function automatic void refit_curve();
    longint pm, p0, p1, p2;
    for (int ax = 0; ax < 2; ax++) begin
      pm = points[ax]; p0 = points[2+ax]; p1 = points[4+ax]; p2 = points[6+ax];
      coefs[4*ax]   = 3*p0 - 3*p1 - pm + p2;
      coefs[4*ax+1] = -5*p0 + 4*p1 + 2*pm - p2;
      coefs[4*ax+2] = p1 - pm;
      coefs[4*ax+3] = 2*p0;
    end
  endfunction

  function automatic longint antiderivative24(longint u);
    longint acc;
    acc = 3 * coefs[4];
    acc = round_by_t(acc, u) + 4 * coefs[5];
    acc = round_by_t(acc, u) + 6 * coefs[6];
    acc = round_by_t(acc, u) + 12 * coefs[7];
    return round_by_t(acc, u);
  endfunction

  function automatic res_t predict_curve(req_t r);
    res_t o;
    longint t, te, p, d;
    logic clip;
    o = '0;
    clip = 1'b0;
    t = (r.t > T_ONE) ? T_ONE : r.t;
    te = (r.t_end > T_ONE) ? T_ONE : r.t_end;
    if (r.func == FUNC_EVAL) begin
      for (int ax = 0; ax < 2; ax++) begin
        p = coefs[4*ax];
        d = 3 * coefs[4*ax];
        p = round_by_t(p, t) + coefs[4*ax+1];
        p = round_by_t(p, t) + coefs[4*ax+2];
        p = round_by_t(p, t) + coefs[4*ax+3];
        d = round_by_t(d, t) + 2 * coefs[4*ax+1];
        d = round_by_t(d, t) + coefs[4*ax+2];
        if (ax == 0) begin
          o.pos_x = saturate(round_div(p, 2), clip);
          o.slope_x = saturate(round_div(d, 2), clip);
        end else begin
          o.pos_y = saturate(round_div(p, 2), clip);
          o.slope_y = saturate(round_div(d, 2), clip);
        end
      end
    end else begin
      o.area = saturate(round_div(antiderivative24(te) - antiderivative24(t), 24), clip);
    end
    o.clipped = clip;
    return o;
  endfunction

  // Write one control point register; only called while the pipeline is idle.
  task automatic write_point(reg_idx_t idx, logic [COORD_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    points[idx] = longint'($signed(value));
    refit_curve();
  endtask

  // Writes arrive back to back; the enable drops after the last one.
  task automatic set_curve(logic [COORD_W-1:0] v [8]);
    for (int i = 0; i < 8; i++) write_point(reg_idx_t'(i), v[i]);
    cfg_we <= 1'b0;
  endtask

  // Offer one request after a random gap and wait until it is taken.
  // Valid stays high afterwards so that a following request can go back to back.
  task automatic send_request(logic func, logic [T_W-1:0] t, logic [T_W-1:0] t_end);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
    if ($urandom_range(0, 1) == 0) gap = 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= '{func: func, t: t, t_end: t_end};
    do @(posedge clk); while (req_stall);
    expected_results.push_back(predict_curve('{func: func, t: t, t_end: t_end}));
  endtask

  task automatic drain_pipeline();
    req_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [T_W-1:0] random_t();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return T_ONE;
      2: return T_W'($urandom_range(T_ONE + 1, (1 << T_W) - 1));
      default: return T_W'($urandom_range(0, T_ONE));
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] random_coord();
    case ($urandom_range(0, 5))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2: return $urandom();
      default: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
    endcase
  endfunction

  // Extremes of the parameter, clamping, reversed limits and both functions.
  task automatic test_directed();
    logic [COORD_W-1:0] pts [8];
    pts = '{32'hFFFF_0000, 32'h0001_0000, 32'h0000_0000, 32'h0002_8000,
            32'h0003_0000, 32'hFFFE_0000, 32'h0005_0000, 32'h0000_4000};
    set_curve(pts);
    send_request(FUNC_EVAL, '0, '0);
    send_request(FUNC_EVAL, T_ONE, '0);
    send_request(FUNC_EVAL, T_ONE >> 1, '1);
    send_request(FUNC_EVAL, '1, '1);
    send_request(FUNC_AREA, '0, T_ONE);
    send_request(FUNC_AREA, T_ONE, '0);
    send_request(FUNC_AREA, '1, '0);
    send_request(FUNC_AREA, 17'h0_8000, 17'h0_8000);
    drain_pipeline();
    // Control points at the coordinate limits, so that some outputs saturate.
    pts = '{COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
            COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN};
    set_curve(pts);
    send_request(FUNC_EVAL, '0, '0);
    send_request(FUNC_EVAL, 17'h0_4000, '0);
    send_request(FUNC_EVAL, T_ONE, '0);
    send_request(FUNC_AREA, '0, T_ONE);
    send_request(FUNC_AREA, T_ONE, '0);
    drain_pipeline();
    pts = '{default: COORD_MAX};
    set_curve(pts);
    send_request(FUNC_EVAL, 17'h0_8000, '0);
    send_request(FUNC_AREA, '0, T_ONE);
    drain_pipeline();
  endtask

  // Random requests over several random curves.
  task automatic test_random();
    logic [COORD_W-1:0] pts [8];
    for (int phase = 0; phase < 10; phase++) begin
      foreach (pts[i]) pts[i] = random_coord();
      set_curve(pts);
      for (int n = 0; n < 150; n++)
        send_request($urandom_range(0, 1), random_t(), random_t());
      drain_pipeline();
    end
  endtask

  // The receiver holds off while requests keep coming, so the pipeline backs up.
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (120) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int n = 0; n < 40; n++) begin
        req_valid <= 1'b1;
        req <= '{func: n[0], t: random_t(), t_end: random_t()};
        do @(posedge clk); while (req_stall);
        expected_results.push_back(predict_curve(req));
      end
    join
    drain_pipeline();
  endtask

  // Receiver stall pattern: a fresh random wait before each result.
  initial begin
    int wait_cycles;
    @(negedge rst);
    forever begin
      wait_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
      if (wait_cycles > 0 || hold_off) begin
        res_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
        while (hold_off) @(posedge clk);
      end
      res_stall <= 1'b0;
      do @(posedge clk); while (!res_valid);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding");
        failures++;
      end else begin
        want = expected_results.pop_front();
        if (res.pos_x !== want.pos_x) begin
          $error("pos_x expected %0d got %0d", want.pos_x, res.pos_x); failures++;
        end
        if (res.pos_y !== want.pos_y) begin
          $error("pos_y expected %0d got %0d", want.pos_y, res.pos_y); failures++;
        end
        if (res.slope_x !== want.slope_x) begin
          $error("slope_x expected %0d got %0d", want.slope_x, res.slope_x); failures++;
        end
        if (res.slope_y !== want.slope_y) begin
          $error("slope_y expected %0d got %0d", want.slope_y, res.slope_y); failures++;
        end
        if (res.area !== want.area) begin
          $error("area expected %0d got %0d", want.area, res.area); failures++;
        end
        if (res.clipped !== want.clipped) begin
          $error("clipped expected %0d got %0d", want.clipped, res.clipped); failures++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted request, result or register write.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (res_valid && !res_stall) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 8; i++) points[i] = 0;
    refit_curve();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random();
    drain_pipeline();
    if (failures == 0 && expected_results.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
